// ===== rtl/core/wsos_pkg.sv =====
// ============================================================================
// wsos_pkg - shared types and constants of the windowed sum of squares
// Fixed field widths, configuration register indexes and the control group
// between the top level and the line store.
// ============================================================================
package wsos_pkg;

  // Fixed field widths
  localparam int COLOR_W   = 8;
  localparam int SQ_W      = 16;
  localparam int ENERGY_W  = 18;
  localparam int COLSUM_W  = 22;
  localparam int SUM_W     = 26;
  localparam int RASTER_W  = 11;
  localparam int WIN_REG_W = 5;
  localparam int ROW_W     = 10;
  localparam int MAX_ROWS  = 1024;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RASTER_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

  // Line store control: read on pixel accept, write when the result stage advances
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ls_ctl_t;

endpackage

// ===== rtl/core/wsos_line_store.sv =====
// ============================================================================
// wsos_line_store - energy line ring and column sum memories
// Registered reads at pixel accept, writes from the result stage, with
// bypass of a write landing on the address read in the same cycle.
// ============================================================================
module wsos_line_store #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 16,
  parameter int CW         = 10,
  parameter int SW         = 4
) (
  input  logic                          clk_i,
  input  wsos_pkg::ls_ctl_t             ctl_i,
  input  logic [CW-1:0]                 rd_col_i,
  input  logic [SW-1:0]                 rd_slot_i,
  input  logic [CW-1:0]                 wr_col_i,
  input  logic [SW-1:0]                 wr_slot_i,
  input  logic [wsos_pkg::ENERGY_W-1:0] wr_energy_i,
  input  logic [wsos_pkg::COLSUM_W-1:0] wr_colsum_i,
  output logic [wsos_pkg::ENERGY_W-1:0] rd_energy_o,
  output logic [wsos_pkg::COLSUM_W-1:0] rd_colsum_o
);

  logic [wsos_pkg::ENERGY_W-1:0] energy_mem [MAX_WINDOW][MAX_WIDTH];
  logic [wsos_pkg::COLSUM_W-1:0] colsum_mem [MAX_WIDTH];

  logic [wsos_pkg::ENERGY_W-1:0] energy_rd_q, energy_fwd_q;
  logic [wsos_pkg::COLSUM_W-1:0] colsum_rd_q, colsum_fwd_q;
  logic                          energy_hit_q, colsum_hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      energy_mem[wr_slot_i][wr_col_i] <= wr_energy_i;
      colsum_mem[wr_col_i]            <= wr_colsum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      energy_rd_q <= energy_mem[rd_slot_i][rd_col_i];
      colsum_rd_q <= colsum_mem[rd_col_i];
    end
  end

  // Bypass: a same-edge write is not yet visible in the array read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      energy_hit_q <= ctl_i.wr_en && (wr_col_i == rd_col_i) && (wr_slot_i == rd_slot_i);
      colsum_hit_q <= ctl_i.wr_en && (wr_col_i == rd_col_i);
      energy_fwd_q <= wr_energy_i;
      colsum_fwd_q <= wr_colsum_i;
    end
  end

  assign rd_energy_o = energy_hit_q ? energy_fwd_q : energy_rd_q;
  assign rd_colsum_o = colsum_hit_q ? colsum_fwd_q : colsum_rd_q;

endmodule

// ===== rtl/core/windowed_sum_of_squares.sv =====
// ============================================================================
// windowed_sum_of_squares - streaming box sum of pixel energy
// Per-pixel sum of red^2 + green^2 + blue^2 over a window ending at the pixel.
// ============================================================================
// Pixels arrive in raster order, one request per clock at most, and every
// pixel yields exactly one result two stages later: the sum of energies of
// the window_width by window_height window whose bottom right corner is that
// pixel, clipped at the top and left raster edges. Unknown pixels count as
// zero energy. The sustained rate is one pixel per clock unless the result
// channel stalls the output. The pace is set by the line store
// memories, which are read once when a pixel is accepted and written once
// when its result is registered; a write and a read to the same location in
// one cycle are bypassed, so narrow rasters and short windows run at full
// rate too. Raise frame_start on the first pixel of a frame; frame_end marks
// the last pixel (raster_width x raster_height), after which counters restart.
// Any configuration write restarts the frame. Register values outside their
// legal range are clamped. No clearing pass is needed after reset: every
// line store location is written in a frame before it is read.
module windowed_sum_of_squares #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Pixel request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wsos_pkg::COLOR_W-1:0]   red_i,
  input  logic [wsos_pkg::COLOR_W-1:0]   green_i,
  input  logic [wsos_pkg::COLOR_W-1:0]   blue_i,
  input  logic                           known_i,
  input  logic                           frame_start_i,
  // Result request channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wsos_pkg::SUM_W-1:0]     window_sum_o,
  output logic                           frame_end_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wsos_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wsos_pkg::RASTER_W-1:0]  cfg_data_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int SW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WWW = $clog2(MAX_WINDOW + 1);

  localparam int EW = wsos_pkg::ENERGY_W;
  localparam int CS = wsos_pkg::COLSUM_W;
  localparam int SM = wsos_pkg::SUM_W;
  localparam int RW = wsos_pkg::ROW_W;
  localparam int RG = wsos_pkg::RASTER_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RG-1:0]                  raster_width_q, raster_height_q;
  logic [wsos_pkg::WIN_REG_W-1:0] window_width_q, window_height_q;
  logic                           cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_width_q  <= RG'(1024);
      raster_height_q <= RG'(1024);
      window_width_q  <= wsos_pkg::WIN_REG_W'(8);
      window_height_q <= wsos_pkg::WIN_REG_W'(8);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        wsos_pkg::REG_RASTER_WIDTH:  raster_width_q  <= cfg_data_i;
        wsos_pkg::REG_RASTER_HEIGHT: raster_height_q <= cfg_data_i;
        wsos_pkg::REG_WINDOW_WIDTH:  window_width_q  <= cfg_data_i[wsos_pkg::WIN_REG_W-1:0];
        wsos_pkg::REG_WINDOW_HEIGHT: window_height_q <= cfg_data_i[wsos_pkg::WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers into their legal ranges
  logic [WCW-1:0] width_c;
  logic [RG-1:0]  height_c;
  logic [WWW-1:0] win_w_c, win_h_c;

  always_comb begin
    if (raster_width_q == '0) begin
      width_c = WCW'(1);
    end else if (32'(raster_width_q) > 32'(MAX_WIDTH)) begin
      width_c = WCW'(MAX_WIDTH);
    end else begin
      width_c = WCW'(raster_width_q);
    end
    if (raster_height_q == '0) begin
      height_c = RG'(1);
    end else if (32'(raster_height_q) > 32'(wsos_pkg::MAX_ROWS)) begin
      height_c = RG'(wsos_pkg::MAX_ROWS);
    end else begin
      height_c = raster_height_q;
    end
    if (window_width_q == '0) begin
      win_w_c = WWW'(1);
    end else if (32'(window_width_q) > 32'(MAX_WINDOW)) begin
      win_w_c = WWW'(MAX_WINDOW);
    end else begin
      win_w_c = WWW'(window_width_q);
    end
    if (window_height_q == '0) begin
      win_h_c = WWW'(1);
    end else if (32'(window_height_q) > 32'(MAX_WINDOW)) begin
      win_h_c = WWW'(MAX_WINDOW);
    end else begin
      win_h_c = WWW'(window_height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: position counters, energy, line store read addresses
  // --------------------------------------------------------------------------
  logic          in_acc;
  logic          s1_adv;
  logic          s1_valid_q;
  logic          out_valid_q;

  logic [CW-1:0] col_q, col_d, col0;
  logic [RW-1:0] row_q, row_d, row0;
  logic [SW-1:0] slot_q, slot_d, slot0, old_slot0;
  logic          row_end0, last0;
  logic [EW-1:0] energy0;
  logic [wsos_pkg::SQ_W-1:0] r_sq, g_sq, b_sq;

  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Frame start takes the pixel as row 0, column 0
  assign col0  = frame_start_i ? '0 : col_q;
  assign row0  = frame_start_i ? '0 : row_q;
  assign slot0 = frame_start_i ? '0 : slot_q;

  assign row_end0 = (32'(col0) + 32'd1) == 32'(width_c);
  assign last0    = row_end0 && ((32'(row0) + 32'd1) == 32'(height_c));

  // Ring slot of the line that leaves the window
  always_comb begin
    if (32'(slot0) >= 32'(win_h_c)) begin
      old_slot0 = SW'(32'(slot0) - 32'(win_h_c));
    end else begin
      old_slot0 = SW'(32'(slot0) + 32'(MAX_WINDOW) - 32'(win_h_c));
    end
  end

  assign r_sq    = wsos_pkg::SQ_W'(red_i)   * wsos_pkg::SQ_W'(red_i);
  assign g_sq    = wsos_pkg::SQ_W'(green_i) * wsos_pkg::SQ_W'(green_i);
  assign b_sq    = wsos_pkg::SQ_W'(blue_i)  * wsos_pkg::SQ_W'(blue_i);
  assign energy0 = known_i ? (EW'(r_sq) + EW'(g_sq) + EW'(b_sq)) : '0;

  // Advance position: wrap at row end, restart after the last pixel or a config write
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (cfg_wr) begin
      col_d  = '0;
      row_d  = '0;
      slot_d = '0;
    end else if (in_acc) begin
      if (last0) begin
        col_d  = '0;
        row_d  = '0;
        slot_d = '0;
      end else if (row_end0) begin
        col_d  = '0;
        row_d  = row0 + RW'(1);
        slot_d = (slot0 == SW'(MAX_WINDOW - 1)) ? '0 : slot0 + SW'(1);
      end else begin
        col_d  = col0 + CW'(1);
        row_d  = row0;
        slot_d = slot0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] s1_col_q;
  logic [SW-1:0] s1_slot_q;
  logic [EW-1:0] s1_energy_q;
  logic          s1_row_zero_q, s1_drop_old_q, s1_col_zero_q, s1_drop_left_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q       <= col0;
      s1_slot_q      <= slot0;
      s1_energy_q    <= energy0;
      s1_row_zero_q  <= (row0 == '0);
      s1_drop_old_q  <= 32'(row0) >= 32'(win_h_c);
      s1_col_zero_q  <= (col0 == '0);
      s1_drop_left_q <= 32'(col0) >= 32'(win_w_c);
      s1_last_q      <= last0;
    end
  end

  // --------------------------------------------------------------------------
  // Line store
  // --------------------------------------------------------------------------
  wsos_pkg::ls_ctl_t ls_ctl;
  logic [EW-1:0]     old_energy;
  logic [CS-1:0]     prev_colsum;
  logic [CS-1:0]     colsum1;

  assign ls_ctl.rd_en = in_acc;
  assign ls_ctl.wr_en = s1_adv;

  wsos_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW),
    .CW        (CW),
    .SW        (SW)
  ) u_line_store (
    .clk_i      (clk_i),
    .ctl_i      (ls_ctl),
    .rd_col_i   (col0),
    .rd_slot_i  (old_slot0),
    .wr_col_i   (s1_col_q),
    .wr_slot_i  (s1_slot_q),
    .wr_energy_i(s1_energy_q),
    .wr_colsum_i(colsum1),
    .rd_energy_o(old_energy),
    .rd_colsum_o(prev_colsum)
  );

  // --------------------------------------------------------------------------
  // Column and row window sums
  // --------------------------------------------------------------------------
  logic [CS-1:0] recent_q [MAX_WINDOW];
  logic [SM-1:0] row_sum_q;
  logic [SM-1:0] row_sum1;
  logic [SW-1:0] left_tap;

  // Column sum: drop the line leaving the window, add this pixel (mod 2^22)
  assign colsum1 = (s1_row_zero_q ? '0 : prev_colsum)
                 - (s1_drop_old_q ? CS'(old_energy) : '0)
                 + CS'(s1_energy_q);

  // Column sum that leaves the row window sits at tap ww-1, ww columns back in the line
  assign left_tap = SW'(32'(win_w_c) - 32'd1);

  assign row_sum1 = (s1_col_zero_q ? '0 : row_sum_q)
                  - (s1_drop_left_q ? SM'(recent_q[left_tap]) : '0)
                  + SM'(colsum1);

  assign s1_adv = s1_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      recent_q[0] <= colsum1;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        recent_q[i] <= recent_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
    end else if (s1_adv) begin
      row_sum_q <= row_sum1;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [SM-1:0] window_sum_q;
  logic          frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      window_sum_q <= row_sum1;
      frame_end_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_sum_o = window_sum_q;
  assign frame_end_o  = frame_end_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The first pixel of a frame sees an empty window: its sum is its own energy
  a_first_pixel_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_row_zero_q && s1_col_zero_q |-> row_sum1 == SM'(s1_energy_q))
    else $error("first pixel window sum differs from its energy");

  // Column counter stays inside the configured raster width
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(width_c))
    else $error("column counter beyond raster width");

  // Position counters are back at the origin while the last pixel is in flight
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q |-> col_q == '0 && row_q == '0 && slot_q == '0)
    else $error("counters not restarted after last pixel of frame");

endmodule
